// File: rtl/cfbms_pkg.sv
// package: shared types, constants and the format weight table of the best-match selector
`default_nettype none

package cfbms_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int COUNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int INDEX_W      = 8;
    localparam int FORMAT_COUNT = 18;

    typedef logic signed [4:0] weight_t;

    localparam weight_t WEIGHT_NONE = -5'sd1;

    // per-format priority, negative means the format never qualifies
    localparam weight_t WEIGHT_TABLE [FORMAT_COUNT] = '{
        5'sd1,  5'sd15, 5'sd15, 5'sd15, 5'sd12, 5'sd12, -5'sd1, -5'sd1, 5'sd13,
        5'sd13, 5'sd13, 5'sd13, 5'sd5,  -5'sd1, 5'sd10, 5'sd10, 5'sd10, 5'sd9
    };

    typedef enum logic [7:0] {
        CFG_REQ_WIDTH        = 8'd0,
        CFG_REQ_HEIGHT       = 8'd1,
        CFG_REQ_INTERVAL     = 8'd2,
        CFG_PREFERRED_FORMAT = 8'd3
    } cfg_reg_t;

    localparam logic signed [5:0] PREF_NONE = -6'sd1;

    typedef struct packed {
        logic [15:0]       req_width;
        logic [15:0]       req_height;
        logic [31:0]       req_interval;
        logic signed [5:0] preferred_format;
    } cfg_t;

    typedef struct packed {
        logic [15:0] min_width;
        logic [15:0] max_width;
        logic [15:0] min_height;
        logic [15:0] max_height;
        logic [31:0] min_interval;
        logic [31:0] max_interval;
        logic [4:0]  format_code;
        logic        last_entry;
    } entry_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] best_index;
        logic [31:0]        best_interval;
    } result_t;

    typedef struct packed {
        logic step;
        logic last;
    } scan_ctl_t;

    function automatic weight_t format_weight(input logic [4:0] code);
        weight_t w;
        w = WEIGHT_NONE;
        if (code < 5'(FORMAT_COUNT))
        begin
            w = WEIGHT_TABLE[code];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/capture_format_best_match_selector_unit.sv
// top level: capture format best-match selector with config registers and result register
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  min/max width, height, interval, format_code, last_entry
//  out      output     out_valid / out_stall found, best_index, best_interval
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one entry per cycle, unless a last entry is held back by a stall on out; a result
// is presented after its last entry is taken: the entry sits in the entry register, then
// the result register captures the outcome and out_valid rises
// the entry register feeds the scan logic directly, the running best lives there
// reset clears config to defaults (no preferred format) and the scan state
// stall on out only holds back an entry marked last; other entries keep flowing
// cfg_ready is always high, a write lands in the config registers at the next clock edge
`default_nettype none

module capture_format_best_match_selector_unit
    import cfbms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        min_width,
    input  wire logic [15:0]        max_width,
    input  wire logic [15:0]        min_height,
    input  wire logic [15:0]        max_height,
    input  wire logic [31:0]        min_interval,
    input  wire logic [31:0]        max_interval,
    input  wire logic [4:0]         format_code,
    input  wire logic               last_entry,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found,
    output logic [INDEX_W-1:0]      best_index,
    output logic [31:0]             best_interval,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    // configuration registers
    cfg_t      cfg_reg, cfg_next;

    // entry register in front of the scan logic
    entry_t    entry_reg;
    logic      entry_valid_reg, entry_valid_next;

    // result register toward the out channel
    result_t   res_reg;
    logic      out_valid_reg, out_valid_next;

    logic      in_accept;
    logic      out_free;
    logic      entry_adv;
    logic      res_load;
    scan_ctl_t scan_ctl;
    result_t   scan_result;

    assign cfg_ready = 1'b1;

    // config write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_REQ_WIDTH:        cfg_next.req_width        = cfg_data[15:0];
                CFG_REQ_HEIGHT:       cfg_next.req_height       = cfg_data[15:0];
                CFG_REQ_INTERVAL:     cfg_next.req_interval     = cfg_data;
                CFG_PREFERRED_FORMAT: cfg_next.preferred_format = $signed(cfg_data[5:0]);
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.req_width        <= '0;
            cfg_reg.req_height       <= '0;
            cfg_reg.req_interval     <= '0;
            cfg_reg.preferred_format <= PREF_NONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake: a last entry moves on only when the result register can take it
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        entry_adv = entry_valid_reg && (!entry_reg.last_entry || out_free);
        in_stall  = entry_valid_reg && !entry_adv;
        in_accept = in_valid && !in_stall;
        res_load  = entry_adv && entry_reg.last_entry;

        entry_valid_next = in_accept ? 1'b1 : (entry_adv ? 1'b0 : entry_valid_reg);

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        scan_ctl.step = entry_adv;
        scan_ctl.last = entry_reg.last_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            entry_reg.min_width    <= min_width;
            entry_reg.max_width    <= max_width;
            entry_reg.min_height   <= min_height;
            entry_reg.max_height   <= max_height;
            entry_reg.min_interval <= min_interval;
            entry_reg.max_interval <= max_interval;
            entry_reg.format_code  <= format_code;
            entry_reg.last_entry   <= last_entry;
        end
        if (res_load)
        begin
            res_reg <= scan_result;
        end
    end

    cfbms_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .entry  (entry_reg),
        .ctl    (scan_ctl),
        .result (scan_result)
    );

    assign out_valid     = out_valid_reg;
    assign found         = res_reg.found;
    assign best_index    = res_reg.best_index;
    assign best_interval = res_reg.best_interval;

    // an empty result carries zero index and interval
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (best_index == '0) && (best_interval == '0))
        else $error("empty result with nonzero payload");

    // input is only held back by a waiting entry
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> entry_valid_reg && entry_reg.last_entry && out_valid_reg)
        else $error("input stalled without a blocked last entry");

    // a last entry that moves on shows up as a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("last entry produced no result");

endmodule

`default_nettype wire

// File: rtl/cfbms_scan.sv
// module: per-entry qualification, interval clamp and running best-match state
`default_nettype none

module cfbms_scan
    import cfbms_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire entry_t    entry,
    input  wire scan_ctl_t ctl,
    output result_t        result
);

    logic [COUNT_W-1:0] count_reg,     count_next;
    logic               have_best_reg, have_best_next;
    weight_t            best_pri_reg,  best_pri_next;
    logic [31:0]        best_diff_reg, best_diff_next;
    logic [31:0]        best_ivl_reg,  best_ivl_next;
    logic [INDEX_W-1:0] best_pos_reg,  best_pos_next;

    weight_t            weight;
    logic               size_ok;
    logic               in_window;
    logic [31:0]        clamped;
    logic [31:0]        diff;
    logic               pref_none;
    logic               fmt_match;
    logic               better;

    logic               upd_have;
    weight_t            upd_pri;
    logic [31:0]        upd_diff;
    logic [31:0]        upd_ivl;
    logic [INDEX_W-1:0] upd_pos;

    always_comb
    begin
        weight  = format_weight(entry.format_code);
        size_ok = (entry.min_width  <= cfg.req_width)  && (entry.max_width  >= cfg.req_width) &&
                  (entry.min_height <= cfg.req_height) && (entry.max_height >= cfg.req_height);
        in_window = count_reg < COUNT_W'(MAX_ENTRIES);

        // clamp order kept as is, also for an inverted range
        if (cfg.req_interval > entry.max_interval)
        begin
            clamped = entry.max_interval;
        end
        else if (cfg.req_interval < entry.min_interval)
        begin
            clamped = entry.min_interval;
        end
        else
        begin
            clamped = cfg.req_interval;
        end

        diff = (clamped >= cfg.req_interval) ? (clamped - cfg.req_interval)
                                             : (cfg.req_interval - clamped);

        pref_none = cfg.preferred_format == PREF_NONE;
        fmt_match = !cfg.preferred_format[5] &&
                    (cfg.preferred_format[4:0] == entry.format_code);

        better = in_window && size_ok && !weight[4] && !(diff > best_diff_reg) &&
                 (pref_none ? ((weight > best_pri_reg) || !have_best_reg ||
                               (diff < best_diff_reg))
                            : fmt_match);

        upd_have = have_best_reg;
        upd_pri  = best_pri_reg;
        upd_diff = best_diff_reg;
        upd_ivl  = best_ivl_reg;
        upd_pos  = best_pos_reg;
        if (better)
        begin
            upd_have = 1'b1;
            upd_pri  = weight;
            upd_diff = diff;
            upd_ivl  = clamped;
            upd_pos  = count_reg[INDEX_W-1:0];
        end

        result.found         = upd_have;
        result.best_index    = upd_have ? upd_pos : '0;
        result.best_interval = upd_have ? upd_ivl : '0;

        count_next     = count_reg;
        have_best_next = have_best_reg;
        best_pri_next  = best_pri_reg;
        best_diff_next = best_diff_reg;
        best_ivl_next  = best_ivl_reg;
        best_pos_next  = best_pos_reg;
        if (ctl.step)
        begin
            if (ctl.last)
            begin
                count_next     = '0;
                have_best_next = 1'b0;
                best_pri_next  = WEIGHT_NONE;
                best_diff_next = '1;
                best_ivl_next  = '0;
                best_pos_next  = '0;
            end
            else
            begin
                count_next     = in_window ? (count_reg + COUNT_W'(1)) : count_reg;
                have_best_next = upd_have;
                best_pri_next  = upd_pri;
                best_diff_next = upd_diff;
                best_ivl_next  = upd_ivl;
                best_pos_next  = upd_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            have_best_reg <= 1'b0;
            best_pri_reg  <= WEIGHT_NONE;
            best_diff_reg <= '1;
            best_ivl_reg  <= '0;
            best_pos_reg  <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            have_best_reg <= have_best_next;
            best_pri_reg  <= best_pri_next;
            best_diff_reg <= best_diff_next;
            best_ivl_reg  <= best_ivl_next;
            best_pos_reg  <= best_pos_next;
        end
    end

endmodule

`default_nettype wire

// File: verif/capture_format_best_match_selector_unit_tb.sv
`timescale 1ns / 1ps
// testbench: directed and random scans of capture format lists checked against a best-match predictor

module capture_format_best_match_selector_unit_tb;
    import cfbms_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 6;
    // a result passes the entry register and the result register after its last entry; a little margin on top
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET   = 1700;
    localparam int REG_COUNT     = 4;
    localparam int TIMEOUT_NS    = 400_000 * CLK_PERIOD;

    // format codes used by name in the directed lists
    localparam logic [4:0] FMT_NONE      = 5'd0;
    localparam logic [4:0] FMT_RGB24     = 5'd1;
    localparam logic [4:0] FMT_TOP_B     = 5'd2;
    localparam logic [4:0] FMT_TOP_C     = 5'd3;
    localparam logic [4:0] FMT_W12       = 5'd4;
    localparam logic [4:0] FMT_EXCLUDED  = 5'd6;
    localparam logic [4:0] FMT_W5        = 5'd12;
    localparam logic [4:0] FMT_MJPG      = 5'd17;
    localparam logic [4:0] FMT_UNDEFINED = 5'd31;

    // negative preference that is not "no preference": nothing can win
    localparam logic signed [5:0] PREF_BAD = -6'sd2;

    // priority per format code, negative never qualifies
    localparam int FORMAT_WEIGHT [FORMAT_COUNT] = '{
        1, 15, 15, 15, 12, 12, -1, -1, 13, 13, 13, 13, 5, -1, 10, 10, 10, 9
    };

    // running best-match prediction plus the queue of results still owed by the block
    class best_match_tracker;
        logic [15:0]       want_width;
        logic [15:0]       want_height;
        logic [31:0]       want_interval;
        logic signed [5:0] want_format;

        int          entry_count;
        bit          have_best;
        int          best_priority;
        logic [31:0] best_difference;
        logic [31:0] best_clamped;
        int          best_position;

        result_t expected_picks[$];
        int      errors;
        int      entries_seen;
        int      picks_checked;
        int      matches_seen;

        function new();
            want_width    = '0;
            want_height   = '0;
            want_interval = '0;
            want_format   = PREF_NONE;
            errors        = 0;
            entries_seen  = 0;
            picks_checked = 0;
            matches_seen  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            entry_count     = 0;
            have_best       = 1'b0;
            best_priority   = -1;
            best_difference = '1;
            best_clamped    = '0;
            best_position   = 0;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // unknown indexes are dropped, upper data bits are ignored
        function void write_reg(logic [7:0] idx, logic [31:0] data);
            case (idx)
                CFG_REQ_WIDTH:        want_width    = data[15:0];
                CFG_REQ_HEIGHT:       want_height   = data[15:0];
                CFG_REQ_INTERVAL:     want_interval = data;
                CFG_PREFERRED_FORMAT: want_format   = data[5:0];
                default: ;
            endcase
        endfunction

        function void note_entry(entry_t e);
            logic [31:0] clamped;
            logic [31:0] diff;
            int          w;
            bit          fits;
            bit          win;
            result_t     r;
            entries_seen++;
            // entries past the list capacity only count toward the last mark
            if (entry_count < MAX_ENTRIES)
            begin
                fits = e.min_width <= want_width && e.max_width >= want_width &&
                       e.min_height <= want_height && e.max_height >= want_height;
                w = (e.format_code < FORMAT_COUNT) ? FORMAT_WEIGHT[e.format_code] : -1;
                if (want_interval > e.max_interval)
                    clamped = e.max_interval;
                else if (want_interval < e.min_interval)
                    clamped = e.min_interval;
                else
                    clamped = want_interval;
                diff = (clamped >= want_interval) ? clamped - want_interval
                                                  : want_interval - clamped;
                if (fits && w >= 0 && diff <= best_difference)
                begin
                    if (want_format == PREF_NONE)
                        win = w > best_priority || !have_best || diff < best_difference;
                    else
                        win = int'(e.format_code) == int'(want_format);
                    if (win)
                    begin
                        best_difference = diff;
                        best_clamped    = clamped;
                        best_position   = entry_count;
                        best_priority   = w;
                        have_best       = 1'b1;
                    end
                end
                entry_count++;
            end
            if (e.last_entry)
            begin
                r.found         = have_best;
                r.best_index    = have_best ? best_position[INDEX_W-1:0] : '0;
                r.best_interval = have_best ? best_clamped : '0;
                expected_picks.push_back(r);
                clear_scan();
            end
        endfunction

        function void check_pick(logic got_found, logic [INDEX_W-1:0] got_index,
                                 logic [31:0] got_interval);
            result_t want;
            if (expected_picks.size() == 0)
            begin
                $error("unexpected scan result: found %0d best_index %0d best_interval %0d",
                       got_found, got_index, got_interval);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            picks_checked++;
            if (want.found)
                matches_seen++;
            if (got_found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got_found);
                errors++;
            end
            if (got_index !== want.best_index)
            begin
                $error("best_index: expected %0d, actual %0d", want.best_index, got_index);
                errors++;
            end
            if (got_interval !== want.best_interval)
            begin
                $error("best_interval: expected %0d, actual %0d",
                       want.best_interval, got_interval);
                errors++;
            end
        endfunction
    endclass

    // every block input starts at a known value
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [15:0]         min_width    = '0;
    logic [15:0]         max_width    = '0;
    logic [15:0]         min_height   = '0;
    logic [15:0]         max_height   = '0;
    logic [31:0]         min_interval = '0;
    logic [31:0]         max_interval = '0;
    logic [4:0]          format_code  = '0;
    logic                last_entry   = 1'b0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                found;
    logic [INDEX_W-1:0]  best_index;
    logic [31:0]         best_interval;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_index    = '0;
    logic [31:0]         cfg_data     = '0;

    best_match_tracker tracker;
    // calm phases run both sides flat out
    bit calm = 1'b1;
    int settings_applied = 0;

    capture_format_best_match_selector_unit u_top (.*);

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("capture_format_best_match_selector_unit test failed");
        $finish;
    end

    // per-transaction wait, biased toward zero so bursts still happen
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic entry_t cap_entry(logic [15:0] w0, logic [15:0] w1,
                                         logic [15:0] h0, logic [15:0] h1,
                                         logic [31:0] i0, logic [31:0] i1,
                                         logic [4:0] fmt, logic last);
        entry_t e;
        e.min_width    = w0;
        e.max_width    = w1;
        e.min_height   = h0;
        e.max_height   = h1;
        e.min_interval = i0;
        e.max_interval = i1;
        e.format_code  = fmt;
        e.last_entry   = last;
        return e;
    endfunction

    // mostly entries that fit the request, with interval ranges placed around it so
    // that distances tie often; one in ten is raw noise
    function automatic entry_t random_entry(logic last);
        entry_t      e;
        logic [31:0] req;
        logic [31:0] off;
        req = tracker.want_interval;
        if ($urandom_range(0, 9) == 0)
        begin
            e = cap_entry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom, $urandom, 5'($urandom), last);
            return e;
        end
        e.min_width  = 16'($urandom_range(0, tracker.want_width));
        e.max_width  = 16'($urandom_range(tracker.want_width, 16'hFFFF));
        e.min_height = 16'($urandom_range(0, tracker.want_height));
        e.max_height = 16'($urandom_range(tracker.want_height, 16'hFFFF));
        // occasional size miss
        if ($urandom_range(0, 7) == 0)
            e.min_width = 16'($urandom);
        if ($urandom_range(0, 7) == 0)
            e.max_height = 16'($urandom);
        off = ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:
            begin
                e.min_interval = req - off;
                e.max_interval = req + 32'($urandom_range(0, 3));
            end
            1:
            begin
                e.min_interval = req + off;
                e.max_interval = e.min_interval + 32'($urandom_range(0, 100));
            end
            2:
            begin
                e.max_interval = req - off;
                e.min_interval = e.max_interval - 32'($urandom_range(0, 100));
            end
            default:
            begin
                e.min_interval = $urandom;
                e.max_interval = $urandom;
            end
        endcase
        // lean on the preferred format when one is set
        if (tracker.want_format >= 0 && tracker.want_format < FORMAT_COUNT &&
            $urandom_range(0, 1) == 1)
            e.format_code = 5'(tracker.want_format);
        else if ($urandom_range(0, 7) == 0)
            e.format_code = 5'($urandom);
        else
            e.format_code = 5'($urandom_range(0, FORMAT_COUNT - 1));
        e.last_entry = last;
        return e;
    endfunction

    // one input transaction; valid stays high across back-to-back entries
    task automatic send_entry(entry_t e);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        min_width    <= e.min_width;
        max_width    <= e.max_width;
        min_height   <= e.min_height;
        max_height   <= e.max_height;
        min_interval <= e.min_interval;
        max_interval <= e.max_interval;
        format_code  <= e.format_code;
        last_entry   <= e.last_entry;
        do @(posedge clk); while (!(in_valid && !in_stall));
        tracker.note_entry(e);
    endtask

    // hold off input until every owed result is out and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid is left high between writes of one batch
    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        tracker.write_reg(idx, data);
    endtask

    // full register update while idle; junk in the upper data bits must be ignored
    task automatic configure(logic [15:0] w, logic [15:0] h, logic [31:0] iv,
                             logic signed [5:0] pref);
        drain();
        write_reg(CFG_REQ_WIDTH, {16'($urandom), w});
        write_reg(CFG_REQ_HEIGHT, {16'($urandom), h});
        write_reg(CFG_REQ_INTERVAL, iv);
        write_reg(CFG_PREFERRED_FORMAT, {26'($urandom), pref});
        // sometimes a write to an index that does not exist
        if ($urandom_range(0, 2) == 0)
            write_reg(8'($urandom_range(REG_COUNT, 255)), $urandom);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic random_settings();
        logic [15:0]       w;
        logic [15:0]       h;
        logic [31:0]       iv;
        logic signed [5:0] pref;
        case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = '1;
            2:       w = 16'($urandom);
            default: w = 16'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 5))
            0:       h = '0;
            1:       h = '1;
            2:       h = 16'($urandom);
            default: h = 16'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 5))
            0:       iv = '0;
            1:       iv = '1;
            2:       iv = $urandom;
            default: iv = 32'($urandom_range(0, 2_000_000));
        endcase
        case ($urandom_range(0, 5))
            0, 1:    pref = PREF_NONE;
            2:       pref = 6'($urandom);
            default: pref = 6'($urandom_range(0, FORMAT_COUNT - 1));
        endcase
        configure(w, h, iv, pref);
    endtask

    // result side: stall a random number of cycles, then take one transaction
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_pick(found, best_index, best_interval);
    end

    initial
    begin
        int phase;
        int lists;
        int len;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers: request 0 x 0 at interval 0, no preference
        // a single degenerate entry that still fits
        send_entry(cap_entry(16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, FMT_RGB24, 1'b1));
        // excluded and unknown formats skipped, then smaller distance, then higher
        // weight on an equal distance
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd5, 32'd9,
                             FMT_EXCLUDED, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd5, 32'd9,
                             FMT_UNDEFINED, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd3, 32'd7,
                             FMT_NONE, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd2, 32'hFFFF_FFFF,
                             FMT_W5, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd2, 32'hFFFF_FFFF,
                             FMT_RGB24, 1'b1));
        // width miss only: empty result
        send_entry(cap_entry(16'h1, 16'hFFFF, 16'h0, 16'hFFFF, 32'h0, 32'h0,
                             FMT_RGB24, 1'b1));

        // largest request, preference on the last format code, inverted interval range
        configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, FMT_MJPG);
        send_entry(cap_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF,
                             FMT_RGB24, 1'b0));
        send_entry(cap_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'd10,
                             FMT_MJPG, 1'b0));
        send_entry(cap_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd20, 32'd5,
                             FMT_MJPG, 1'b0));
        send_entry(cap_entry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFE,
                             FMT_MJPG, 1'b1));

        // negative preference other than none: nothing may be selected
        configure(16'd100, 16'd200, 32'd1000, PREF_BAD);
        send_entry(cap_entry(16'd0, 16'd100, 16'd200, 16'hFFFF, 32'd0, 32'd2000,
                             FMT_RGB24, 1'b0));
        send_entry(cap_entry(16'd100, 16'd100, 16'd200, 16'd200, 32'd1000, 32'd1000,
                             FMT_MJPG, 1'b1));

        // equal weight and equal distance keeps the earlier entry
        configure(16'd640, 16'd480, 32'd333333, PREF_NONE);
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd333333, 32'd333333,
                             FMT_TOP_B, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd333333, 32'd400000,
                             FMT_TOP_C, 1'b0));
        send_entry(cap_entry(16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd0, 32'd333330,
                             FMT_W12, 1'b1));

        // random lists under random settings; two phases carry a list as long as the block
        // can track or longer
        calm  = 1'b0;
        phase = 0;
        while (tracker.entries_seen < ITEM_TARGET)
        begin
            phase++;
            random_settings();
            calm  = ($urandom_range(0, 4) == 0);
            lists = $urandom_range(2, 8);
            for (int i = 0; i < lists; i++)
            begin
                if ((phase == 3 || phase == 17) && i == 0)
                    len = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 40);
                else
                    len = $urandom_range(1, 10);
                for (int j = 0; j < len; j++)
                    send_entry(random_entry(j == len - 1));
                // sender pauses until the block has caught up
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end

        drain();
        $display("run covered %0d list entries and %0d scan results, %0d with a match,",
                 tracker.entries_seen, tracker.picks_checked, tracker.matches_seen);
        $display("across %0d register settings including extreme requests and overlong lists",
                 settings_applied);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("capture_format_best_match_selector_unit test passed");
        else
            $display("capture_format_best_match_selector_unit test failed");
        $finish;
    end

endmodule
